>>> src/ccws_pkg.sv
// shared types, constants and helpers of the comment and whitespace stripper
// used by ccws_ctrl, ccws_datapath and the top level
package ccws_pkg;

  localparam int MAX_DELIM = 16;
  localparam int WIN_LEN   = MAX_DELIM + 2;
  localparam int DL_W      = $clog2(MAX_DELIM + 1);
  localparam int RI_W      = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;
  localparam int WIN_W     = $clog2(WIN_LEN);
  localparam int CNT_W     = $clog2(WIN_LEN + 1);
  localparam int OK_W      = $clog2(MAX_DELIM + 2);

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_NL     = 8'h0A;

  typedef struct packed {
    logic [7:0] in_char;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       run_last;
    logic       text_end;
    logic       delim_overflow;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic handle;
    logic open_step;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic start_open;
    logic open_done;
    logic end_done;
  } ctrl_stat_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

endpackage

>>> src/ccws_ctrl.sv
// sequencer of the stripper: idle, byte handling, raw-prefix emission, flush
// depends on ccws_pkg
module ccws_ctrl import ccws_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  ctrl_stat_t stat_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_HANDLE = 4'b0010,
    ST_OPEN   = 4'b0100,
    ST_FLUSH  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_HANDLE;
        end
      end
      ST_HANDLE: begin
        if (stat_i.out_free) begin
          cmd_o.handle = 1'b1;
          if (stat_i.start_open) state_d = ST_OPEN;
          else if (stat_i.end_done) state_d = ST_FLUSH;
        end
      end
      ST_OPEN: begin
        if (stat_i.out_free) begin
          cmd_o.open_step = 1'b1;
          if (stat_i.open_done) state_d = ST_HANDLE;
        end
      end
      ST_FLUSH: begin
        if (stat_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/ccws_datapath.sv
// scan state, delimiter buffer, raw tail window, replay source and output stage
// depends on ccws_pkg
module ccws_datapath import ccws_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_data_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_data_i,
  input  ctrl_cmd_t  cmd_i,
  output ctrl_stat_t stat_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o
);

  typedef enum logic [3:0] {
    M_NORMAL, M_SLASH, M_LINE, M_BLOCK, M_STR, M_STR_ESC,
    M_CHR, M_CHR_ESC, M_RAW, M_RPEND, M_PREFIX
  } mode_e;

  typedef enum logic [1:0] {
    SRC_NONE, SRC_CUR, SRC_QUOTE, SRC_DELIM
  } src_e;

  mode_e             mode_q, mode_d;
  src_e              src_q, src_d;
  logic              star_q, star_d;
  logic [DL_W-1:0]   dl_q, dl_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic [7:0]        win_q [WIN_LEN];
  logic [7:0]        win_d [WIN_LEN];
  logic [7:0]        win_sh [WIN_LEN];
  logic [DL_W-1:0]   rep_len_q, rep_len_d;
  logic [RI_W-1:0]   rep_idx_q, rep_idx_d;
  logic              has_cur_q, has_cur_d;
  logic [OK_W-1:0]   open_k_q, open_k_d;
  logic [7:0]        cur_q;
  logic              last_q;
  logic              hold_v_q, hold_v_d;
  logic [7:0]        hold_ch_q, hold_ch_d;
  logic              out_v_q, out_v_d;
  out_item_t         out_q, out_d;
  logic              drop_q;

  logic [7:0]        delim_mem [MAX_DELIM];
  logic              dwe;
  logic [RI_W-1:0]   rd_addr;
  logic [7:0]        delim_rd;
  logic [OK_W-1:0]   open_km1;

  logic [7:0]        b;
  logic              adv, fb, fb_cur;
  logic              emit_en;
  logic [7:0]        emit_ch;
  logic              kept;
  logic              closed;
  logic [CNT_W-1:0]  cnt_new;
  logic [WIN_W-1:0]  widx;
  logic              out_free;

  assign out_free = !out_v_q || !out_stall_i;
  assign open_km1 = open_k_q - OK_W'(1);
  assign rd_addr  = cmd_i.open_step ? open_km1[RI_W-1:0] : rep_idx_q;
  assign delim_rd = delim_mem[rd_addr];

  always_comb begin
    case (src_q)
      SRC_CUR:   b = cur_q;
      SRC_QUOTE: b = CH_DQUOTE;
      SRC_DELIM: b = delim_rd;
      default:   b = 8'h00;
    endcase
  end

  // raw string close: ")delim"" at the tail of the shifted window
  always_comb begin
    for (int i = 0; i < WIN_LEN - 1; i++) win_sh[i] = win_q[i + 1];
    win_sh[WIN_LEN - 1] = b;
    cnt_new = (cnt_q < CNT_W'(WIN_LEN)) ? cnt_q + CNT_W'(1) : cnt_q;
    closed  = (cnt_new >= CNT_W'(dl_q) + CNT_W'(2))
           && (win_sh[WIN_W'(WIN_LEN - 2) - WIN_W'(dl_q)] == CH_RPAREN)
           && (win_sh[WIN_LEN - 1] == CH_DQUOTE);
    for (int m = 0; m < MAX_DELIM; m++) begin
      widx = '0;
      if (m < int'(dl_q)) begin
        widx = WIN_W'(WIN_LEN - 1 - int'(dl_q) + m);
        if (win_sh[widx] != delim_mem[m]) closed = 1'b0;
      end
    end
  end

  always_comb begin
    mode_d    = mode_q;
    src_d     = src_q;
    star_d    = star_q;
    dl_d      = dl_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    win_d     = win_q;
    rep_len_d = rep_len_q;
    rep_idx_d = rep_idx_q;
    has_cur_d = has_cur_q;
    open_k_d  = open_k_q;
    hold_v_d  = hold_v_q;
    hold_ch_d = hold_ch_q;
    out_v_d   = out_v_q && out_stall_i;
    out_d     = out_q;
    adv       = 1'b0;
    fb        = 1'b0;
    fb_cur    = 1'b0;
    dwe       = 1'b0;
    emit_en   = 1'b0;
    emit_ch   = b;
    stat_o    = '0;
    stat_o.out_free = out_free;

    if (cmd_i.load) begin
      src_d = SRC_CUR;
    end

    if (cmd_i.handle) begin
      if (src_q == SRC_NONE) begin
        stat_o.end_done = 1'b1;
        if (last_q) begin
          case (mode_q)
            M_PREFIX: begin
              stat_o.end_done = 1'b0;
              fb              = 1'b1;
            end
            M_RPEND: begin
              emit_en = 1'b1;
              emit_ch = CH_R;
            end
            M_SLASH: begin
              emit_en = 1'b1;
              emit_ch = CH_SLASH;
            end
            default: ;
          endcase
        end
      end else begin
        case (mode_q)
          M_NORMAL: begin
            adv = 1'b1;
            if (b == CH_SLASH) mode_d = M_SLASH;
            else if (b == CH_DQUOTE) begin
              emit_en = 1'b1;
              mode_d  = M_STR;
            end else if (b == CH_SQUOTE) begin
              emit_en = 1'b1;
              mode_d  = M_CHR;
            end else if (b == CH_R) mode_d = M_RPEND;
            else emit_en = 1'b1;
          end
          M_SLASH: begin
            if (b == CH_SLASH) begin
              mode_d = M_LINE;
              adv    = 1'b1;
            end else if (b == CH_STAR) begin
              mode_d = M_BLOCK;
              star_d = 1'b0;
              adv    = 1'b1;
            end else begin
              // not a comment: emit the slash, rescan the byte
              emit_en = 1'b1;
              emit_ch = CH_SLASH;
              mode_d  = M_NORMAL;
            end
          end
          M_LINE: begin
            adv = 1'b1;
            if (b == CH_NL) begin
              emit_en = 1'b1;
              mode_d  = M_NORMAL;
            end
          end
          M_BLOCK: begin
            adv = 1'b1;
            if (star_q && b == CH_SLASH) begin
              mode_d = M_NORMAL;
              star_d = 1'b0;
            end else star_d = (b == CH_STAR);
          end
          M_STR: begin
            adv     = 1'b1;
            emit_en = 1'b1;
            if (b == CH_BSLASH) mode_d = M_STR_ESC;
            else if (b == CH_DQUOTE) mode_d = M_NORMAL;
          end
          M_STR_ESC: begin
            adv     = 1'b1;
            emit_en = 1'b1;
            mode_d  = M_STR;
          end
          M_CHR: begin
            adv     = 1'b1;
            emit_en = 1'b1;
            if (b == CH_BSLASH) mode_d = M_CHR_ESC;
            else if (b == CH_SQUOTE) mode_d = M_NORMAL;
          end
          M_CHR_ESC: begin
            adv     = 1'b1;
            emit_en = 1'b1;
            mode_d  = M_CHR;
          end
          M_RAW: begin
            adv     = 1'b1;
            emit_en = 1'b1;
            win_d   = win_sh;
            cnt_d   = cnt_new;
            if (closed) mode_d = M_NORMAL;
          end
          M_RPEND: begin
            if (b == CH_DQUOTE) begin
              mode_d = M_PREFIX;
              dl_d   = '0;
              adv    = 1'b1;
            end else begin
              emit_en = 1'b1;
              emit_ch = CH_R;
              mode_d  = M_NORMAL;
            end
          end
          M_PREFIX: begin
            if (b == CH_LPAREN) begin
              // R goes out now, the rest of the prefix in the open sequence
              emit_en           = 1'b1;
              emit_ch           = CH_R;
              mode_d            = M_RAW;
              cnt_d             = '0;
              open_k_d          = '0;
              stat_o.start_open = 1'b1;
            end else if (b == CH_NL) begin
              fb     = 1'b1;
              fb_cur = 1'b1;
            end else if (dl_q >= DL_W'(MAX_DELIM)) begin
              ovf_d  = 1'b1;
              fb     = 1'b1;
              fb_cur = 1'b1;
            end else begin
              dwe  = 1'b1;
              dl_d = dl_q + DL_W'(1);
              adv  = 1'b1;
            end
          end
          default: mode_d = M_NORMAL;
        endcase
      end
    end

    if (cmd_i.open_step) begin
      emit_en  = 1'b1;
      open_k_d = open_k_q + OK_W'(1);
      if (open_k_q == '0) emit_ch = CH_DQUOTE;
      else if (open_k_q <= OK_W'(dl_q)) emit_ch = delim_rd;
      else begin
        emit_ch          = CH_LPAREN;
        stat_o.open_done = 1'b1;
        adv              = 1'b1;
      end
    end

    // fallback: R out, then quote, delimiter and maybe the byte are rescanned
    if (fb) begin
      emit_en   = 1'b1;
      emit_ch   = CH_R;
      mode_d    = M_NORMAL;
      src_d     = SRC_QUOTE;
      rep_len_d = dl_q;
      has_cur_d = fb_cur;
      dl_d      = '0;
    end

    if (adv) begin
      case (src_q)
        SRC_QUOTE: begin
          if (rep_len_q != '0) begin
            src_d     = SRC_DELIM;
            rep_idx_d = '0;
          end else src_d = has_cur_q ? SRC_CUR : SRC_NONE;
        end
        SRC_DELIM: begin
          if (DL_W'(rep_idx_q) + DL_W'(1) < rep_len_q) begin
            rep_idx_d = rep_idx_q + RI_W'(1);
          end else src_d = has_cur_q ? SRC_CUR : SRC_NONE;
        end
        default: src_d = SRC_NONE;
      endcase
    end

    kept = emit_en && !(drop_q && is_ws(emit_ch));
    if (kept) begin
      if (hold_v_q) begin
        out_v_d              = 1'b1;
        out_d.out_char       = hold_ch_q;
        out_d.char_valid     = 1'b1;
        out_d.run_last       = 1'b0;
        out_d.text_end       = 1'b0;
        out_d.delim_overflow = ovf_q;
      end
      hold_v_d  = 1'b1;
      hold_ch_d = emit_ch;
    end

    if (cmd_i.flush) begin
      if (hold_v_q || last_q) begin
        out_v_d              = 1'b1;
        out_d.out_char       = hold_v_q ? hold_ch_q : 8'h00;
        out_d.char_valid     = hold_v_q;
        out_d.run_last       = 1'b1;
        out_d.text_end       = last_q;
        out_d.delim_overflow = ovf_q;
      end
      hold_v_d = 1'b0;
      if (last_q) begin
        mode_d = M_NORMAL;
        star_d = 1'b0;
        dl_d   = '0;
        cnt_d  = '0;
        ovf_d  = 1'b0;
        for (int i = 0; i < WIN_LEN; i++) win_d[i] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= M_NORMAL;
      src_q     <= SRC_NONE;
      star_q    <= 1'b0;
      dl_q      <= '0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      for (int i = 0; i < WIN_LEN; i++) win_q[i] <= 8'h00;
      rep_len_q <= '0;
      rep_idx_q <= '0;
      has_cur_q <= 1'b0;
      open_k_q  <= '0;
      last_q    <= 1'b0;
      hold_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      drop_q    <= 1'b1;
    end else begin
      mode_q    <= mode_d;
      src_q     <= src_d;
      star_q    <= star_d;
      dl_q      <= dl_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      win_q     <= win_d;
      rep_len_q <= rep_len_d;
      rep_idx_q <= rep_idx_d;
      has_cur_q <= has_cur_d;
      open_k_q  <= open_k_d;
      hold_v_q  <= hold_v_d;
      out_v_q   <= out_v_d;
      if (cmd_i.load) last_q <= in_data_i.last_char;
      if (cfg_valid_i) drop_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) cur_q <= in_data_i.in_char;
    hold_ch_q <= hold_ch_d;
    out_q     <= out_d;
    if (dwe) delim_mem[dl_q[RI_W-1:0]] <= b;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_dl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dl_q <= DL_W'(MAX_DELIM))
    else $error("delimiter length beyond bound");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(WIN_LEN))
    else $error("raw count beyond window");

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |=> !hold_v_q)
    else $error("held byte survives flush");

  a_open_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.open_step |-> open_k_q <= OK_W'(dl_q) + OK_W'(1))
    else $error("open sequence overran delimiter");

  a_last_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.text_end |-> out_q.run_last)
    else $error("end of text without end of run");

endmodule

>>> src/cpp_comment_whitespace_stripper.sv
// top level of the C++ comment and whitespace stripper
// depends on ccws_pkg, ccws_ctrl and ccws_datapath
//
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one source byte
// per item; last_char marks the final byte of a text. Output channel
// (out_valid_o / out_stall_i / out_data_o) returns the kept bytes, each with
// run_last on the final result of its input item and text_end on the final
// result of the text. A text whose last item keeps nothing yields one bare
// end marker (char_valid low). cfg_valid_i / cfg_ready_o / cfg_data_i write
// drop_whitespace; ready is always high, writes belong in idle time.
// One item at a time: an ordinary byte goes through accept, scan, end check
// and flush, plus one step per extra byte it emits or rescans. Opening a raw
// string adds an open sequence of quote, delimiter and parenthesis; a raw
// prefix that falls back rescans its quote, buffered delimiter and any byte.
// One result is held back to learn whether it ends the run; results leave
// through an output register, and the scanner waits whenever that register
// is full and stalled. Reset clears all scan state and sets drop_whitespace.
module cpp_comment_whitespace_stripper import ccws_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  assign cfg_ready_o = 1'b1;

  ccws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ccws_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> verif/tb_cpp_comment_whitespace_stripper.sv
// testbench of the C++ comment and whitespace stripper: directed and random texts
// are pushed through the byte stream and every kept byte is checked against a
// behavioral predictor; depends on ccws_pkg and cpp_comment_whitespace_stripper
module tb_cpp_comment_whitespace_stripper;
  import ccws_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    SC_CODE, SC_SLASH, SC_LINE, SC_BLOCK, SC_STR, SC_STR_ESC,
    SC_CHR, SC_CHR_ESC, SC_RAW, SC_RPEND, SC_PREFIX
  } scan_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_data_i = 1'b0;

  cpp_comment_whitespace_stripper u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic       strip_ws = 1'b1;
  scan_e      mode = SC_CODE;
  logic       star_pend;
  logic [7:0] delim [MAX_DELIM];
  int         delim_len;
  logic [7:0] tail [WIN_LEN];
  int         tail_cnt;
  logic       ovf;
  logic [7:0] rescan_q [$];
  logic [7:0] kept_q [$];

  out_item_t  kept_items_q [$];
  int         errors = 0;
  int         n_checked = 0;
  int         n_texts = 0;
  int         n_sent = 0;
  int         gap_left = 0;

  function automatic void keep(logic [7:0] c);
    if (strip_ws && is_ws(c)) return;
    kept_q = {kept_q, c};
  endfunction

  function automatic void clear_text();
    mode = SC_CODE;
    star_pend = 1'b0;
    delim_len = 0;
    foreach (tail[i]) tail[i] = 8'h00;
    tail_cnt = 0;
    ovf = 1'b0;
    rescan_q.delete();
  endfunction

  // R" prefix that is not a raw string: R is code, quote and delimiter rescanned
  function automatic void prefix_fallback(logic has_cur, logic [7:0] cur);
    logic [7:0] tmp [$];
    keep(CH_R);
    mode = SC_CODE;
    tmp = {CH_DQUOTE};
    for (int i = 0; i < delim_len; i++) tmp = {tmp, delim[i]};
    if (has_cur) tmp = {tmp, cur};
    delim_len = 0;
    rescan_q = {tmp, rescan_q};
  endfunction

  function automatic logic raw_ends();
    int len;
    int base;
    len = delim_len + 2;
    if (len > WIN_LEN || tail_cnt < len) return 1'b0;
    base = WIN_LEN - len;
    if (tail[base] != CH_RPAREN) return 1'b0;
    for (int m = 0; m < delim_len; m++)
      if (tail[base + 1 + m] != delim[m]) return 1'b0;
    return tail[WIN_LEN - 1] == CH_DQUOTE;
  endfunction

  // returns 1 when the byte must be scanned again in the new mode
  function automatic logic scan_byte(logic [7:0] c);
    case (mode)
      SC_CODE: begin
        if (c == CH_SLASH) mode = SC_SLASH;
        else if (c == CH_DQUOTE) begin keep(c); mode = SC_STR; end
        else if (c == CH_SQUOTE) begin keep(c); mode = SC_CHR; end
        else if (c == CH_R) mode = SC_RPEND;
        else keep(c);
      end
      SC_SLASH: begin
        if (c == CH_SLASH) mode = SC_LINE;
        else if (c == CH_STAR) begin mode = SC_BLOCK; star_pend = 1'b0; end
        else begin keep(CH_SLASH); mode = SC_CODE; return 1'b1; end
      end
      SC_LINE: if (c == CH_NL) begin keep(c); mode = SC_CODE; end
      SC_BLOCK: begin
        if (star_pend && c == CH_SLASH) begin mode = SC_CODE; star_pend = 1'b0; end
        else star_pend = (c == CH_STAR);
      end
      SC_STR: begin
        keep(c);
        if (c == CH_BSLASH) mode = SC_STR_ESC;
        else if (c == CH_DQUOTE) mode = SC_CODE;
      end
      SC_STR_ESC: begin keep(c); mode = SC_STR; end
      SC_CHR: begin
        keep(c);
        if (c == CH_BSLASH) mode = SC_CHR_ESC;
        else if (c == CH_SQUOTE) mode = SC_CODE;
      end
      SC_CHR_ESC: begin keep(c); mode = SC_CHR; end
      SC_RAW: begin
        keep(c);
        for (int i = 0; i < WIN_LEN - 1; i++) tail[i] = tail[i + 1];
        tail[WIN_LEN - 1] = c;
        if (tail_cnt < WIN_LEN) tail_cnt++;
        if (raw_ends()) mode = SC_CODE;
      end
      SC_RPEND: begin
        if (c == CH_DQUOTE) begin mode = SC_PREFIX; delim_len = 0; end
        else begin keep(CH_R); mode = SC_CODE; return 1'b1; end
      end
      SC_PREFIX: begin
        if (c == CH_LPAREN) begin
          keep(CH_R); keep(CH_DQUOTE);
          for (int i = 0; i < delim_len; i++) keep(delim[i]);
          keep(CH_LPAREN);
          mode = SC_RAW;
          tail_cnt = 0;
        end else if (c == CH_NL) begin
          prefix_fallback(1'b1, c);
        end else if (delim_len >= MAX_DELIM) begin
          ovf = 1'b1;
          prefix_fallback(1'b1, c);
        end else begin
          delim[delim_len] = c;
          delim_len++;
        end
      end
      default: begin mode = SC_CODE; return 1'b1; end
    endcase
    return 1'b0;
  endfunction

  function automatic void drain_rescan();
    logic [7:0] c;
    while (rescan_q.size() > 0) begin
      c = rescan_q.pop_front();
      while (scan_byte(c)) ;
    end
  endfunction

  function automatic void predict_byte(in_item_t it);
    out_item_t r;
    int n;
    kept_q.delete();
    rescan_q = {rescan_q, it.in_char};
    drain_rescan();
    if (it.last_char) begin
      while (mode == SC_PREFIX) begin
        prefix_fallback(1'b0, 8'h00);
        drain_rescan();
      end
      if (mode == SC_RPEND) keep(CH_R);
      else if (mode == SC_SLASH) keep(CH_SLASH);
    end
    n = kept_q.size();
    for (int k = 0; k < n; k++) begin
      r.out_char       = kept_q[k];
      r.char_valid     = 1'b1;
      r.run_last       = (k == n - 1);
      r.text_end       = it.last_char && (k == n - 1);
      r.delim_overflow = ovf;
      kept_items_q = {kept_items_q, r};
    end
    if (it.last_char && n == 0) begin
      r = '0;
      r.run_last = 1'b1;
      r.text_end = 1'b1;
      r.delim_overflow = ovf;
      kept_items_q = {kept_items_q, r};
    end
    if (it.last_char) begin
      clear_text();
      n_texts++;
    end
  endfunction

  // sender bursts with random gaps between them
  task automatic send_byte(logic [7:0] c, logic last);
    in_item_t it;
    it.in_char = c;
    it.last_char = last;
    if (gap_left == 0 && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      gap_left = $urandom_range(1, 20);
    end
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_byte(it);
    n_sent++;
    if (gap_left > 0) gap_left--;
    @(negedge clk_i);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (kept_items_q.size() > 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_strip_ws(logic v);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    strip_ws = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver stall pattern: calm stretches and heavy stretches
  initial begin
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 40) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(20, 60)) @(negedge clk_i);
      end else begin
        case ($urandom_range(0, 2))
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (kept_items_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $realtime, out_data_o);
        errors++;
      end else begin
        exp_r = kept_items_q.pop_front();
        n_checked++;
        if (out_data_o !== exp_r) begin
          $display("%0t: mismatch, expected %p, actual %p", $realtime, exp_r, out_data_o);
          errors++;
        end
      end
    end
  end

  task automatic test_comments();
    send_text("a/b//x\ny/*q**/z");
    send_text("/* open");
    send_text("/");
  endtask

  task automatic test_literals();
    send_text("\"a//\\\"b\"'\\''c");
    send_text("\"x\\");
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_raw_strings();
    send_text("R\"ab(x)\"y)ab\"z");
    send_text("Rq R\"d\ne");
    send_text("R\"abc");
    send_text("R");
    send_text("R\"0123456789abcdefg(z");
  endtask

  task automatic test_whitespace();
    send_text(" \t\n\v\f\r a b ");
    send_text("//c\n");
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0: return CH_SLASH;
      1: return CH_STAR;
      2: return CH_DQUOTE;
      3: return CH_SQUOTE;
      4: return CH_BSLASH;
      5: return CH_R;
      6: return CH_LPAREN;
      7: return CH_RPAREN;
      8: return CH_NL;
      9: return 8'h20;
      10: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(8'h61, 8'h64));
    endcase
  endfunction

  task automatic send_raw_string();
    int dl;
    logic [7:0] d [$];
    dl = ($urandom_range(0, 9) == 0) ? MAX_DELIM : $urandom_range(0, 3);
    for (int i = 0; i < dl; i++) d = {d, 8'($urandom_range(8'h61, 8'h63))};
    send_byte(CH_R, 1'b0);
    send_byte(CH_DQUOTE, 1'b0);
    foreach (d[i]) send_byte(d[i], 1'b0);
    send_byte(CH_LPAREN, 1'b0);
    repeat ($urandom_range(0, 5)) send_byte(pick_byte(), 1'b0);
    send_byte(CH_RPAREN, 1'b0);
    foreach (d[i]) send_byte(d[i], 1'b0);
    send_byte(CH_DQUOTE, 1'b0);
  endtask

  task automatic test_random(int n_items);
    int start;
    int tlen;
    start = n_sent;
    while (n_sent - start < n_items) begin
      tlen = $urandom_range(1, 30);
      for (int i = 0; i < tlen; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_raw_string();
        end else if ($urandom_range(0, 12) == 0) begin
          send_text("/*c*/");
        end else begin
          send_byte(pick_byte(), 1'b0);
        end
      end
      send_byte(pick_byte(), 1'b1);
    end
  endtask

  initial begin
    clear_text();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_comments();
    test_literals();
    test_raw_strings();
    test_whitespace();
    settle();
    write_strip_ws(1'b0);
    test_whitespace();
    test_raw_strings();
    test_random(150);
    settle();
    write_strip_ws(1'b1);
    test_random(150);
    settle();
    $display("checked %0d results from %0d bytes over %0d texts, whitespace drop on and off",
             n_checked, n_sent, n_texts);
    if (errors == 0 && kept_items_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, kept_items_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", kept_items_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
